// ===== rtl/cdas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_pkg: shared types and helpers for the calendar date add/subtract block
// Holds the request and result layouts, the queue entry, operation codes and
// the Gregorian month-length and leap-year helpers.
// ----------------------------------------------------------------------------
package cdas_pkg;

	localparam int AMOUNT_BITS = 16;

	localparam logic [13:0] YEAR_MAX     = 14'd9999;
	localparam logic [13:0] YEAR_MIN     = 14'd1;
	localparam logic [3:0]  MONTH_LAST   = 4'd12;
	localparam logic [6:0]  YLO_LAST     = 7'd99;

	// floor(y / 100) as (y * 5243) >> 19, exact for any 14-bit year
	localparam logic [26:0] CENT_RECIP = 27'd5243;
	localparam int          CENT_SHIFT = 19;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [2:0] FN_ADD_DAYS   = 3'd0;
	localparam logic [2:0] FN_ADD_MONTHS = 3'd1;
	localparam logic [2:0] FN_ADD_YEARS  = 3'd2;
	localparam logic [2:0] FN_SUB_DAYS   = 3'd3;
	localparam logic [2:0] FN_SUB_MONTHS = 3'd4;
	localparam logic [2:0] FN_SUB_YEARS  = 3'd5;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_ECHO,
		OP_INVALID,
		OP_DAYS,
		OP_MONTHS,
		OP_YEARS
	} op_t;

	typedef struct packed {
		logic [2:0]             func;
		logic [AMOUNT_BITS-1:0] amount;
		logic [4:0]             in_day;
		logic [3:0]             in_month;
		logic [13:0]            in_year;
	} req_t;

	typedef struct packed {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [1:0]  status;
	} rsp_t;

	// Classified request as it waits between the front and the back.
	typedef struct packed {
		op_t                    op;
		logic                   sub;
		logic [AMOUNT_BITS-1:0] amount;
		logic [4:0]             day;
		logic [3:0]             month;
		logic [13:0]            year;
		logic [6:0]             yhi;
		logic [6:0]             ylo;
	} ent_t;

	// Leap rule on a year split into century and year within century.
	function automatic logic is_leap(input logic [6:0] yhi, input logic [6:0] ylo);
		logic leap;
		if (ylo == 7'd0) begin
			leap = (yhi[1:0] == 2'd0);
		end else begin
			leap = (ylo[1:0] == 2'd0);
		end
		return leap;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month) inside
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/cdas_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_front: request intake and classification
// Registers a request, splits the year into century and remainder, checks
// the date and pushes a classified entry into the queue.
// ----------------------------------------------------------------------------
module cdas_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cdas_pkg::req_t req,
	output logic           busy,
	output logic           push,
	output cdas_pkg::ent_t ent,
	input  logic           full
);
	import cdas_pkg::*;

	logic        vld_s1;
	req_t        req_s1;
	logic [7:0]  cent_s1;
	logic [26:0] cent_prod;
	logic [13:0] cent_x100;
	logic [13:0] lo_full;
	logic [6:0]  ylo;
	logic        leap;
	logic        date_ok;
	logic        take;

	assign take      = start && !busy;
	assign cent_prod = 27'(req.in_year) * CENT_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1  <= req;
			cent_s1 <= cent_prod[CENT_SHIFT +: 8];
		end
	end

	always_comb begin
		cent_x100 = (14'(cent_s1) << 6) + (14'(cent_s1) << 5) + (14'(cent_s1) << 2);
		lo_full   = req_s1.in_year - cent_x100;
		ylo       = lo_full[6:0];
		leap      = is_leap(cent_s1[6:0], ylo);
		date_ok   = (req_s1.in_month != 4'd0) && (req_s1.in_month <= MONTH_LAST)
			&& (req_s1.in_year >= YEAR_MIN) && (req_s1.in_year <= YEAR_MAX)
			&& (req_s1.in_day != 5'd0)
			&& (req_s1.in_day <= month_days(req_s1.in_month, leap));

		ent.sub    = (req_s1.func >= FN_SUB_DAYS);
		ent.amount = req_s1.amount;
		ent.day    = req_s1.in_day;
		ent.month  = req_s1.in_month;
		ent.year   = req_s1.in_year;
		ent.yhi    = cent_s1[6:0];
		ent.ylo    = ylo;
		if (!date_ok) begin
			ent.op = OP_INVALID;
		end else begin
			unique case (req_s1.func) inside
				FN_ADD_DAYS, FN_SUB_DAYS:     ent.op = OP_DAYS;
				FN_ADD_MONTHS, FN_SUB_MONTHS: ent.op = OP_MONTHS;
				FN_ADD_YEARS, FN_SUB_YEARS:   ent.op = OP_YEARS;
				default:                      ent.op = OP_ECHO;
			endcase
		end
	end

	assign push = vld_s1 && !full;
	assign busy = vld_s1 && full;

endmodule

// ===== rtl/cdas_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_fifo: short queue of classified requests
// Decouples the intake stage from the sequential date engine.
// ----------------------------------------------------------------------------
module cdas_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdas_pkg::ent_t wdata,
	output logic           full,
	input  logic           pop,
	output cdas_pkg::ent_t rdata,
	output logic           empty
);
	import cdas_pkg::*;

	ent_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/cdas_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_back: sequential date engine
// Walks the date one day, one month, one year or one century per cycle
// until the amount is used up (then clamps the day) or the year leaves its range, and issues the result.
// ----------------------------------------------------------------------------
module cdas_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  cdas_pkg::ent_t ent,
	output logic           pop,
	output logic           done,
	output cdas_pkg::rsp_t rsp
);
	import cdas_pkg::*;

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t                 state_q;
	logic                   done_q;
	rsp_t                   rsp_q;
	ent_t                   ent_q;
	logic [4:0]             day_q;
	logic [3:0]             mon_q;
	logic [13:0]            yr_q;
	logic [6:0]             yhi_q;
	logic [6:0]             ylo_q;
	logic [AMOUNT_BITS-1:0] rem_q;

	logic                   leap_now;
	logic [4:0]             md;
	logic [4:0]             cl_day;
	logic [4:0]             n_day;
	logic [3:0]             n_mon;
	logic [13:0]            n_yr;
	logic [6:0]             n_hi;
	logic [6:0]             n_lo;
	logic [AMOUNT_BITS-1:0] n_rem;
	logic                   yinc;
	logic                   ydec;
	logic                   big;
	logic                   oob;
	logic                   last;

	assign pop      = (state_q == S_IDLE) && !empty;
	assign leap_now = is_leap(yhi_q, ylo_q);
	assign md       = month_days(mon_q, leap_now);
	assign cl_day   = (day_q > md) ? md : day_q;
	assign last     = (rem_q == '0);

	always_comb begin
		n_day = day_q;
		n_mon = mon_q;
		n_yr  = yr_q;
		n_hi  = yhi_q;
		n_lo  = ylo_q;
		n_rem = rem_q - 1'b1;
		yinc  = 1'b0;
		ydec  = 1'b0;
		big   = 1'b0;
		oob   = 1'b0;

		case (ent_q.op)
			OP_DAYS: begin
				if (!ent_q.sub) begin
					if (day_q < md) begin
						n_day = day_q + 1'b1;
					end else begin
						n_day = 5'd1;
						if (mon_q != MONTH_LAST) begin
							n_mon = mon_q + 1'b1;
						end else begin
							n_mon = 4'd1;
							yinc  = 1'b1;
						end
					end
				end else if (day_q != 5'd1) begin
					n_day = day_q - 1'b1;
				end else if (mon_q != 4'd1) begin
					n_mon = mon_q - 1'b1;
					n_day = month_days(mon_q - 4'd1, leap_now);
				end else begin
					n_mon = MONTH_LAST;
					n_day = 5'd31;
					ydec  = 1'b1;
				end
			end
			OP_MONTHS: begin
				if (rem_q >= AMOUNT_BITS'(12)) begin
					n_rem = rem_q - AMOUNT_BITS'(12);
					yinc  = !ent_q.sub;
					ydec  = ent_q.sub;
				end else if (!ent_q.sub) begin
					if (mon_q != MONTH_LAST) begin
						n_mon = mon_q + 1'b1;
					end else begin
						n_mon = 4'd1;
						yinc  = 1'b1;
					end
				end else if (mon_q != 4'd1) begin
					n_mon = mon_q - 1'b1;
				end else begin
					n_mon = MONTH_LAST;
					ydec  = 1'b1;
				end
			end
			OP_YEARS: begin
				big = (rem_q >= AMOUNT_BITS'(100));
				if (big) begin
					n_rem = rem_q - AMOUNT_BITS'(100);
				end
				yinc = !ent_q.sub;
				ydec = ent_q.sub;
			end
			default: begin
			end
		endcase

		// Whole centuries move only the upper part of the split year.
		if (yinc) begin
			if (big) begin
				oob  = (yr_q > YEAR_MAX - 14'd100);
				n_yr = yr_q + 14'd100;
				n_hi = yhi_q + 1'b1;
			end else begin
				oob  = (yr_q == YEAR_MAX);
				n_yr = yr_q + 1'b1;
				if (ylo_q == YLO_LAST) begin
					n_lo = 7'd0;
					n_hi = yhi_q + 1'b1;
				end else begin
					n_lo = ylo_q + 1'b1;
				end
			end
		end else if (ydec) begin
			if (big) begin
				oob  = (yr_q <= 14'd100);
				n_yr = yr_q - 14'd100;
				n_hi = yhi_q - 1'b1;
			end else begin
				oob  = (yr_q == YEAR_MIN);
				n_yr = yr_q - 1'b1;
				if (ylo_q == 7'd0) begin
					n_lo = YLO_LAST;
					n_hi = yhi_q - 1'b1;
				end else begin
					n_lo = ylo_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						case (ent.op)
							OP_INVALID: begin
								done_q <= 1'b1;
								rsp_q  <= '{ent.day, ent.month, ent.year, STAT_INVALID};
							end
							OP_ECHO: begin
								done_q <= 1'b1;
								rsp_q  <= '{ent.day, ent.month, ent.year, STAT_OK};
							end
							default: begin
								state_q <= S_RUN;
							end
						endcase
					end
				end
				S_RUN: begin
					if (last) begin
						done_q  <= 1'b1;
						rsp_q   <= '{cl_day, mon_q, yr_q, STAT_OK};
						state_q <= S_IDLE;
					end else if (oob) begin
						// The walk is monotone, so leaving the year range is final.
						done_q  <= 1'b1;
						rsp_q   <= '{ent_q.day, ent_q.month, ent_q.year, STAT_RANGE};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= ent;
			day_q <= ent.day;
			mon_q <= ent.month;
			yr_q  <= ent.year;
			yhi_q <= ent.yhi;
			ylo_q <= ent.ylo;
			rem_q <= ent.amount;
		end else if (state_q == S_RUN && !last) begin
			day_q <= n_day;
			mon_q <= n_mon;
			yr_q  <= n_yr;
			yhi_q <= n_hi;
			ylo_q <= n_lo;
			rem_q <= n_rem;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/calendar_date_add_subtract.sv =====
`timescale 1ns / 1ps
// Each accepted request passes the intake register and the queue to the date engine, which answers
// an invalid date or an unused func code from its idle state and otherwise walks the amount in steps
// of days for days, years then months for months and centuries then years for years, one per cycle.
// Throughput is one request per engine walk; a two-entry queue lets up to three requests wait.
// Asynchronous active-low reset clears the queue and the engine; done pulses cannot be stalled.
// ----------------------------------------------------------------------------
// calendar_date_add_subtract: Gregorian date add/subtract
// Intake stage, request queue and sequential date engine.
// ----------------------------------------------------------------------------
module calendar_date_add_subtract (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cdas_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output cdas_pkg::rsp_t rsp
);
	import cdas_pkg::*;

	ent_t push_ent;
	ent_t pop_ent;
	logic push;
	logic pop;
	logic full;
	logic empty;

	cdas_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.push   (push),
		.ent    (push_ent),
		.full   (full)
	);

	cdas_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_ent),
		.full   (full),
		.pop    (pop),
		.rdata  (pop_ent),
		.empty  (empty)
	);

	cdas_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.ent    (pop_ent),
		.pop    (pop),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/cdas_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_checker: port-level checks for the date add/subtract block
// Watches the request and result ports and flags impossible results.
// ----------------------------------------------------------------------------
module cdas_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input cdas_pkg::rsp_t rsp
);
	import cdas_pkg::*;

	// Busy can only come up right after a request was taken.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == STAT_OK || rsp.status == STAT_INVALID
			|| rsp.status == STAT_RANGE))
		else $error("result carries an unused status code");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_OK)
			|-> (rsp.out_month != 4'd0 && rsp.out_month <= 4'd12
				&& rsp.out_day != 5'd0 && rsp.out_year != 14'd0
				&& rsp.out_year <= 14'd9999))
		else $error("good result lies outside the calendar");

	a_short_months: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_OK && rsp.out_day == 5'd31)
			|-> (rsp.out_month != 4'd2 && rsp.out_month != 4'd4 && rsp.out_month != 4'd6
				&& rsp.out_month != 4'd9 && rsp.out_month != 4'd11))
		else $error("day 31 in a short month");

	a_feb_30: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_OK && rsp.out_day == 5'd30) |-> (rsp.out_month != 4'd2))
		else $error("day 30 in February");

endmodule

bind calendar_date_add_subtract cdas_checker u_cdas_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== tb/cdas_date_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdas_date_checker: result checker for the calendar date add/subtract block
// Watches the request and result channels, works out the expected date for
// every accepted request and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module cdas_date_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  cdas_pkg::req_t req,
	input  logic           done,
	input  cdas_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending,
	output int             ok_count,
	output int             invalid_count,
	output int             range_count
);
	import cdas_pkg::*;

	localparam int DAYS_PER_400Y = 146097;
	localparam int DAYS_PER_100Y = 36524;
	localparam int DAYS_PER_4Y   = 1461;
	localparam int LAST_DAY_NUM  = 3652058;

	rsp_t predicted_dates[$];
	rsp_t want;
	int   result_index = 0;

	initial begin
		fail_count    = 0;
		pending       = 0;
		ok_count      = 0;
		invalid_count = 0;
		range_count   = 0;
	end

	function automatic bit leap_year(input int year);
		return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
	endfunction

	function automatic int month_length(input int year, input int month);
		int len;
		case (month)
			2: begin
				len = leap_year(year) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				len = 30;
			end
			default: begin
				len = 31;
			end
		endcase
		return len;
	endfunction

	// Day 0 is 0001-01-01.
	function automatic int day_number(input int year, input int month, input int day);
		int prior;
		int num;
		prior = year - 1;
		num   = 365 * prior + prior / 4 - prior / 100 + prior / 400;
		for (int k = 1; k < month; k++) begin
			num += month_length(year, k);
		end
		return num + day - 1;
	endfunction

	function automatic void date_of_day_number(input int num, output int year,
			output int month, output int day);
		int rest;
		int n400;
		int n100;
		int n4;
		int n1;
		n400 = num / DAYS_PER_400Y;
		rest = num % DAYS_PER_400Y;
		n100 = rest / DAYS_PER_100Y;
		// The last day of a 400-year cycle would otherwise count as a fifth century.
		if (n100 == 4) begin
			n100 = 3;
		end
		rest -= n100 * DAYS_PER_100Y;
		n4   = rest / DAYS_PER_4Y;
		rest = rest % DAYS_PER_4Y;
		n1   = rest / 365;
		if (n1 == 4) begin
			n1 = 3;
		end
		rest -= n1 * 365;
		year  = 400 * n400 + 100 * n100 + 4 * n4 + n1 + 1;
		month = 1;
		while (month < 12 && rest >= month_length(year, month)) begin
			rest -= month_length(year, month);
			month++;
		end
		day = rest + 1;
	endfunction

	function automatic rsp_t predict_move(input req_t r);
		rsp_t res;
		int   year;
		int   month;
		int   day;
		int   new_year;
		int   new_month;
		int   new_day;
		int   amt;
		int   num;
		int   months;
		bit   calendar_step;
		year          = r.in_year;
		month         = r.in_month;
		day           = r.in_day;
		amt           = r.amount;
		new_year      = year;
		new_month     = month;
		new_day       = day;
		calendar_step = 1'b0;
		res.out_day   = r.in_day;
		res.out_month = r.in_month;
		res.out_year  = r.in_year;
		res.status    = STAT_OK;
		if (month < 1 || month > 12 || year < 1 || year > 9999 || day < 1 ||
				day > month_length(year, month)) begin
			res.status = STAT_INVALID;
			return res;
		end
		case (r.func)
			FN_ADD_DAYS, FN_SUB_DAYS: begin
				num = day_number(year, month, day) + ((r.func == FN_ADD_DAYS) ? amt : -amt);
				if (num < 0 || num > LAST_DAY_NUM) begin
					res.status = STAT_RANGE;
				end else begin
					date_of_day_number(num, new_year, new_month, new_day);
				end
			end
			FN_ADD_MONTHS, FN_SUB_MONTHS: begin
				months = year * 12 + month - 1 + ((r.func == FN_ADD_MONTHS) ? amt : -amt);
				if (months < 0) begin
					months = 0;
				end
				new_year      = months / 12;
				new_month     = months % 12 + 1;
				calendar_step = 1'b1;
			end
			FN_ADD_YEARS, FN_SUB_YEARS: begin
				new_year      = (r.func == FN_ADD_YEARS) ? year + amt : year - amt;
				calendar_step = 1'b1;
			end
			default: begin
			end
		endcase
		if (calendar_step) begin
			if (new_year < 1 || new_year > 9999) begin
				res.status = STAT_RANGE;
			end else if (new_day > month_length(new_year, new_month)) begin
				new_day = month_length(new_year, new_month);
			end
		end
		if (res.status == STAT_OK) begin
			res.out_day   = 5'(new_day);
			res.out_month = 4'(new_month);
			res.out_year  = 14'(new_year);
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] expected,
			input logic [15:0] actual);
		if (actual !== expected) begin
			$error("result %0d %s: expected %0d, got %0d", result_index, name, expected, actual);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (predicted_dates.size() == 0) begin
					$error("result %0d arrived with no request outstanding", result_index);
					fail_count++;
				end else begin
					want = predicted_dates.pop_front();
					check_field("out_day", 16'(want.out_day), 16'(rsp.out_day));
					check_field("out_month", 16'(want.out_month), 16'(rsp.out_month));
					check_field("out_year", 16'(want.out_year), 16'(rsp.out_year));
					check_field("status", 16'(want.status), 16'(rsp.status));
					case (status_t'(want.status))
						STAT_OK:      ok_count++;
						STAT_INVALID: invalid_count++;
						default:      range_count++;
					endcase
				end
				result_index++;
			end
			if (start && !busy) begin
				predicted_dates.push_back(predict_move(req));
			end
			pending = predicted_dates.size();
		end
	end

endmodule

// ===== tb/calendar_date_add_subtract_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_subtract_test: testbench for the date add/subtract block
// Sends directed calendar corner cases and then random dates with random
// gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module calendar_date_add_subtract_test;
	import cdas_pkg::*;

	localparam logic [2:0] FN_SPARE_LO     = 3'd6;
	localparam logic [2:0] FN_SPARE_HI     = 3'd7;
	localparam int         RANDOM_REQUESTS = 75;
	localparam int         CALM_TAIL       = 25;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	int fail_count;
	int pending;
	int ok_count;
	int invalid_count;
	int range_count;

	longint work_bound  = 0;
	longint cycle_count = 0;
	int     day_moves   = 0;
	int     month_moves = 0;
	int     year_moves  = 0;
	int     spare_moves = 0;
	int     sent        = 0;

	req_t directed[$];

	always #2 clk = ~clk;

	calendar_date_add_subtract u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	cdas_date_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending       (pending),
		.ok_count      (ok_count),
		.invalid_count (invalid_count),
		.range_count   (range_count)
	);

	// The limit grows with the work sent: a day walk takes one engine step per day.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * work_bound + 5000) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic req_t date_request(input logic [2:0] func, input int amount,
			input int day, input int month, input int year);
		req_t r;
		r.func     = func;
		r.amount   = 16'(amount);
		r.in_day   = 5'(day);
		r.in_month = 4'(month);
		r.in_year  = 14'(year);
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   year;
		int   month;
		int   len;
		int   day;
		int   amount;
		logic [2:0] func;
		// A few requests are raw bit noise, mostly invalid dates.
		if ($urandom_range(0, 99) < 8) begin
			r.func     = 3'($urandom);
			r.amount   = 16'($urandom);
			r.in_day   = 5'($urandom);
			r.in_month = 4'($urandom);
			r.in_year  = 14'($urandom);
			return r;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: year = $urandom_range(1, 9999);
			5:             year = $urandom_range(1, 40);
			6:             year = $urandom_range(9960, 9999);
			7:             year = $urandom_range(1, 99) * 100;
			8:             year = $urandom_range(1, 2499) * 4;
			default:       year = $urandom_range(1, 3000);
		endcase
		month = $urandom_range(1, 12);
		case (month)
			2:            len = 28 + $urandom_range(0, 1);
			4, 6, 9, 11:  len = 30;
			default:      len = 31;
		endcase
		day = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9: amount = $urandom_range(0, 40);
			10, 11, 12, 13, 14:           amount = $urandom_range(0, 400);
			15, 16, 17:                   amount = $urandom_range(0, 3000);
			18:                           amount = $urandom_range(0, 20000);
			default:                      amount = $urandom_range(0, 65535);
		endcase
		if ($urandom_range(0, 19) == 0) begin
			func = ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
		end else begin
			func = 3'($urandom_range(0, 5));
		end
		return date_request(func, amount, day, month, year);
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic issue_request(input req_t r);
		work_bound += 30 + r.amount;
		case (r.func)
			FN_ADD_DAYS, FN_SUB_DAYS:     day_moves++;
			FN_ADD_MONTHS, FN_SUB_MONTHS: month_moves++;
			FN_ADD_YEARS, FN_SUB_YEARS:   year_moves++;
			default:                      spare_moves++;
		endcase
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		req   <= random_request();
		repeat (cycles) @(negedge clk);
	endtask

	initial begin
		directed.push_back(date_request(FN_ADD_DAYS, 0, 29, 2, 2024));
		directed.push_back(date_request(FN_ADD_DAYS, 1, 31, 12, 1999));
		directed.push_back(date_request(FN_ADD_DAYS, 1, 28, 2, 2000));
		directed.push_back(date_request(FN_ADD_DAYS, 1, 28, 2, 1900));
		directed.push_back(date_request(FN_SUB_DAYS, 1, 1, 1, 1));
		directed.push_back(date_request(FN_ADD_DAYS, 1, 31, 12, 9999));
		directed.push_back(date_request(FN_ADD_DAYS, 65535, 1, 1, 1));
		directed.push_back(date_request(FN_SUB_DAYS, 65535, 31, 12, 9999));
		directed.push_back(date_request(FN_ADD_MONTHS, 1, 31, 1, 2023));
		directed.push_back(date_request(FN_ADD_MONTHS, 1, 15, 12, 2023));
		directed.push_back(date_request(FN_SUB_MONTHS, 1, 10, 1, 2024));
		directed.push_back(date_request(FN_SUB_MONTHS, 65535, 31, 12, 9999));
		directed.push_back(date_request(FN_ADD_MONTHS, 65535, 1, 1, 2000));
		directed.push_back(date_request(FN_ADD_YEARS, 1, 29, 2, 2024));
		directed.push_back(date_request(FN_SUB_YEARS, 400, 29, 2, 2000));
		directed.push_back(date_request(FN_SUB_YEARS, 65535, 15, 6, 5000));
		directed.push_back(date_request(FN_ADD_YEARS, 9998, 1, 1, 1));
		directed.push_back(date_request(FN_SPARE_LO, 100, 31, 7, 1234));
		directed.push_back(date_request(FN_SPARE_HI, 65535, 30, 11, 8765));
		// Invalid starting dates of every kind.
		directed.push_back(date_request(FN_ADD_DAYS, 5, 10, 0, 2020));
		directed.push_back(date_request(FN_ADD_MONTHS, 5, 10, 15, 2020));
		directed.push_back(date_request(FN_ADD_YEARS, 5, 10, 3, 0));
		directed.push_back(date_request(FN_SUB_DAYS, 5, 10, 3, 16383));
		directed.push_back(date_request(FN_SUB_MONTHS, 5, 0, 3, 2020));
		directed.push_back(date_request(FN_SUB_YEARS, 5, 31, 4, 2020));
		directed.push_back(date_request(FN_SPARE_HI, 5, 29, 2, 1900));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			issue_request(directed[i]);
			if ($urandom_range(0, 2) == 0) begin
				idle_for($urandom_range(1, 13));
			end
		end
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			issue_request(random_request());
			if (i < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				idle_for($urandom_range(1, 13));
			end
		end
		start <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);

		$display("Sent %0d requests (%0d directed): %0d day, %0d month, %0d year, %0d spare.",
			sent, directed.size(), day_moves, month_moves, year_moves, spare_moves);
		$display("Results seen: %0d in range, %0d invalid start date, %0d year out of range.",
			ok_count, invalid_count, range_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
